/* rtl/core/svpwm_pkg.sv */
// Package for the space vector PWM generator: widths, Q24 constants,
// the controller command type and the microcode program.
// No dependencies.
package svpwm_pkg;

  localparam int unsigned FreqW  = 26;
  localparam int unsigned AmplW  = 26;
  localparam int unsigned DutyW  = 26;
  localparam int unsigned SecW   = 3;
  localparam int unsigned ScaleW = 25;
  localparam int unsigned AngW   = 24;
  localparam int unsigned QW     = 25;
  localparam int unsigned MulW   = 32;
  localparam int unsigned ProdW  = 2 * MulW;
  localparam int unsigned EW     = 28;

  localparam logic [ScaleW-1:0] ScaleRst = 25'd503316;
  localparam logic [QW-1:0]     One      = 25'd16777216;
  localparam logic [QW-1:0]     Pi3      = 25'd17569059;
  localparam logic [SecW-1:0]   SecMax   = 3'd5;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_M_STEP, OP_W_ANGLE, OP_M_THETA, OP_W_THETA,
    OP_M_X2, OP_W_X2, OP_M_DIV, OP_W_DIV, OP_M_XT2, OP_W_V, OP_M_XT,
    OP_W_SIN, OP_PERM, OP_M_OUT, OP_W_OUT, OP_PUSH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] sel;
  } cmd_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_PUSH} state_e;

  localparam int unsigned ProgLen = 55;
  localparam int unsigned IdxW    = 6;

  // step list: angle update, theta, sin(theta), sin(pi/3-theta), permute, three duties
  function automatic cmd_t prog(logic [IdxW-1:0] idx);
    cmd_t           c;
    logic [IdxW-1:0] j;
    logic [IdxW-1:0] u;
    c.op  = OP_IDLE;
    c.sel = '0;
    j     = '0;
    u     = '0;
    if (idx < 6'd4) begin
      unique case (idx[1:0])
        2'd0: c.op = OP_M_STEP;
        2'd1: c.op = OP_W_ANGLE;
        2'd2: c.op = OP_M_THETA;
        default: c.op = OP_W_THETA;
      endcase
    end else if (idx < 6'd48) begin
      j = (idx < 6'd26) ? idx - 6'd4 : idx - 6'd26;
      u = j - 6'd2;
      if (j < 6'd2) begin
        c.op = j[0] ? OP_W_X2 : OP_M_X2;
      end else if (j < 6'd20) begin
        c.sel = u[4:2];
        unique case (u[1:0])
          2'd0: c.op = OP_M_DIV;
          2'd1: c.op = OP_W_DIV;
          2'd2: c.op = OP_M_XT2;
          default: c.op = OP_W_V;
        endcase
      end else begin
        c.op  = j[0] ? OP_W_SIN : OP_M_XT;
        c.sel = (idx < 6'd26) ? 3'd0 : 3'd1;
      end
    end else if (idx == 6'd48) begin
      c.op = OP_PERM;
    end else begin
      u     = idx - 6'd49;
      c.op  = u[0] ? OP_W_OUT : OP_M_OUT;
      c.sel = u[3:1];
    end
    return c;
  endfunction

  // floor(2^31 / divisor) of the series terms
  function automatic logic [MulW-1:0] recip(logic [2:0] k);
    logic [MulW-1:0] r;
    unique case (k)
      3'd0: r = 32'd19522578;
      3'd1: r = 32'd29826161;
      3'd2: r = 32'd51130563;
      3'd3: r = 32'd107374182;
      3'd4: r = 32'd357913941;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] divisor(logic [2:0] k);
    logic [6:0] d;
    unique case (k)
      3'd0: d = 7'd110;
      3'd1: d = 7'd72;
      3'd2: d = 7'd42;
      3'd3: d = 7'd20;
      3'd4: d = 7'd6;
      default: d = 7'd1;
    endcase
    return d;
  endfunction

endpackage

/* rtl/core/svpwm_if.sv */
// Request channel interfaces of the space vector PWM generator.
// Depends on svpwm_pkg for the field widths.
interface svpwm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [svpwm_pkg::FreqW-1:0]   freq;
  logic signed [svpwm_pkg::AmplW-1:0]   ampl;
  modport source (output valid, output freq, output ampl, input ready);
  modport sink   (input valid, input freq, input ampl, output ready);
endinterface

interface svpwm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [svpwm_pkg::DutyW-1:0]   duty_a;
  logic signed [svpwm_pkg::DutyW-1:0]   duty_b;
  logic signed [svpwm_pkg::DutyW-1:0]   duty_c;
  logic        [svpwm_pkg::SecW-1:0]    sector;
  modport source (output valid, output duty_a, output duty_b, output duty_c,
                  output sector, input ready);
  modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                  input sector, output ready);
endinterface

/* rtl/core/space_vector_pwm_generator_unit.sv */
// Space vector PWM generator, magnitude/frequency form. Each request of
// frequency and amplitude advances the sector angle by freq*step_scale,
// steps the 0..5 sector counter when the angle wraps, and returns three
// Q24 duties in -1..1 with the current sector. A result is made in 55
// sequencer steps around one shared 32x32 multiplier (27 dependent
// products, each followed by a write-back step), plus the hand-over
// step, which waits while the last result is untaken. Requests are taken
// only in the idle state, so one is done before the next enters. The
// result register lets the next request enter while a result waits.
// Depends on svpwm_pkg, svpwm_if, svpwm_ctrl and svpwm_dp.
module space_vector_pwm_generator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  svpwm_in_if.sink                       in_i,
  svpwm_out_if.source                    out_o,
  input  logic                           cfg_we_i,
  input  logic [svpwm_pkg::ScaleW-1:0]   cfg_wdata_i
);
  import svpwm_pkg::*;

  cmd_t cmd;

  svpwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  svpwm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .freq_i      (in_i.freq),
    .ampl_i      (in_i.ampl),
    .duty_a_o    (out_o.duty_a),
    .duty_b_o    (out_o.duty_b),
    .duty_c_o    (out_o.duty_c),
    .sector_o    (out_o.sector)
  );

endmodule

/* rtl/core/svpwm_dp.sv */
// Datapath: shared 32x32 multiplier, angle/sector state, series registers.
// Depends on svpwm_pkg; driven by svpwm_ctrl commands.
module svpwm_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  svpwm_pkg::cmd_t                     cmd_i,
  input  logic                                cfg_we_i,
  input  logic        [svpwm_pkg::ScaleW-1:0] cfg_wdata_i,
  input  logic signed [svpwm_pkg::FreqW-1:0]  freq_i,
  input  logic signed [svpwm_pkg::AmplW-1:0]  ampl_i,
  output logic signed [svpwm_pkg::DutyW-1:0]  duty_a_o,
  output logic signed [svpwm_pkg::DutyW-1:0]  duty_b_o,
  output logic signed [svpwm_pkg::DutyW-1:0]  duty_c_o,
  output logic        [svpwm_pkg::SecW-1:0]   sector_o
);
  import svpwm_pkg::*;

  logic        [ScaleW-1:0] scale_q;
  logic        [AngW-1:0]   ang_q;
  logic        [SecW-1:0]   sec_q;
  logic signed [FreqW-1:0]  freq_q;
  logic        [QW-1:0]     gain_q;
  logic signed [ProdW-1:0]  p_q;
  logic        [QW-1:0]     theta_q, x_q, x2_q, v_q, t_q, dy_q, dx_q;
  logic signed [EW-1:0]     e_q   [3];
  logic signed [DutyW-1:0]  res_q [3];
  logic signed [DutyW-1:0]  duty_q[3];
  logic        [SecW-1:0]   sec_out_q;

  logic signed [MulW-1:0]   ma, mb;
  logic signed [ProdW-1:0]  prod, ps;
  logic        [AngW-1:0]   ang_new;
  logic        [QW-1:0]     q0, qv;
  logic        [6:0]        dv;
  logic        [8:0]        qd, r9;
  logic signed [EW-1:0]     one_s, dz, ta, tb, tc;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.op)
      OP_M_STEP:  begin ma = {{6{freq_q[FreqW-1]}}, freq_q}; mb = {7'b0, scale_q}; end
      OP_M_THETA: begin ma = {8'b0, ang_q}; mb = {7'b0, Pi3}; end
      OP_M_X2:    begin ma = {7'b0, x_q}; mb = {7'b0, x_q}; end
      OP_M_DIV:   begin ma = {7'b0, v_q}; mb = recip(cmd_i.sel); end
      OP_M_XT2:   begin ma = {7'b0, x2_q}; mb = {7'b0, t_q}; end
      OP_M_XT:    begin ma = {7'b0, x_q}; mb = {7'b0, t_q}; end
      OP_M_OUT:   begin
        ma = {{4{e_q[cmd_i.sel[1:0]][EW-1]}}, e_q[cmd_i.sel[1:0]]};
        mb = {7'b0, gain_q};
      end
      default: ;
    endcase
  end

  assign prod    = ma * mb;
  assign ps      = p_q >>> 24;
  assign ang_new = ang_q + ps[AngW-1:0];

  // reciprocal quotient is exact or one short; remainder lies below 2*divisor
  assign dv = divisor(cmd_i.sel);
  assign q0 = p_q[55:31];
  assign qd = 9'(q0[8:0] * {2'b0, dv});
  assign r9 = v_q[8:0] - qd;
  assign qv = (r9 >= {2'b0, dv}) ? q0 + 25'd1 : q0;

  assign one_s = 28'sd16777216;
  assign dz    = (one_s - $signed({3'b0, dx_q}) - $signed({3'b0, dy_q})) >>> 1;

  always_comb begin
    unique case (sec_q)
      3'd0: begin ta = dz; tb = dz + $signed({3'b0, dx_q}); tc = one_s - dz; end
      3'd1: begin tb = dz; ta = dz + $signed({3'b0, dy_q}); tc = one_s - dz; end
      3'd2: begin tb = dz; tc = dz + $signed({3'b0, dx_q}); ta = one_s - dz; end
      3'd3: begin tc = dz; tb = dz + $signed({3'b0, dy_q}); ta = one_s - dz; end
      3'd4: begin tc = dz; ta = dz + $signed({3'b0, dx_q}); tb = one_s - dz; end
      default: begin ta = dz; tc = dz + $signed({3'b0, dy_q}); tb = one_s - dz; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleRst;
      ang_q   <= '0;
      sec_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_W_ANGLE) begin
        ang_q <= ang_new;
        if (ang_new < ang_q) begin
          sec_q <= (sec_q < SecMax) ? sec_q + 3'd1 : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    unique case (cmd_i.op)
      OP_LOAD: begin
        freq_q <= freq_i;
        if (ampl_i[AmplW-1]) begin
          gain_q <= '0;
        end else if (ampl_i > 26'sd16777216) begin
          gain_q <= One;
        end else begin
          gain_q <= ampl_i[QW-1:0];
        end
      end
      OP_W_THETA: begin
        theta_q <= ps[QW-1:0];
        x_q     <= ps[QW-1:0];
      end
      OP_W_X2: begin
        x2_q <= ps[QW-1:0];
        v_q  <= ps[QW-1:0];
      end
      OP_W_DIV: t_q <= One - qv;
      OP_W_V:   v_q <= ps[QW-1:0];
      OP_W_SIN: begin
        if (cmd_i.sel[0]) begin
          dx_q <= ps[QW-1:0];
        end else begin
          dy_q <= ps[QW-1:0];
          x_q  <= Pi3 - theta_q;
        end
      end
      OP_PERM: begin
        e_q[0] <= (ta <<< 1) - one_s;
        e_q[1] <= (tb <<< 1) - one_s;
        e_q[2] <= (tc <<< 1) - one_s;
      end
      OP_W_OUT: res_q[cmd_i.sel[1:0]] <= ps[DutyW-1:0];
      OP_PUSH: begin
        duty_q    <= res_q;
        sec_out_q <= sec_q;
      end
      default: ;
    endcase
  end

  assign duty_a_o = duty_q[0];
  assign duty_b_o = duty_q[1];
  assign duty_c_o = duty_q[2];
  assign sector_o = sec_out_q;

endmodule

/* rtl/core/svpwm_ctrl.sv */
// Controller: request handshakes and the step sequencer issuing datapath commands.
// Depends on svpwm_pkg.
module svpwm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output svpwm_pkg::cmd_t cmd_o
);
  import svpwm_pkg::*;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic            push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    in_ready_o = 1'b0;
    push       = 1'b0;
    cmd_o.op   = OP_IDLE;
    cmd_o.sel  = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          idx_d    = '0;
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o = prog(idx_q);
        idx_d = idx_q + 6'd1;
        if (idx_q == IdxW'(ProgLen - 1)) begin
          state_d = ST_PUSH;
        end
      end
      default: begin
        if (!out_valid_q || out_ready_i) begin
          push     = 1'b1;
          cmd_o.op = OP_PUSH;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    priority if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_PUSH |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(push))
    else $error("result valid without push");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> idx_q < IdxW'(ProgLen))
    else $error("step index out of range");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("request taken while busy");

endmodule
